FILE: design/mpc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and colour tables of the mandelbrot pixel colouriser
package mpc_pkg;

   localparam int MAX_ITER_DEF   = 60;
   localparam int COORD_BITS_DEF = 11;

   localparam int ITER_BITS = 9;
   localparam int Z_BITS    = 30;
   localparam int PROD_BITS = 2 * Z_BITS;
   localparam int SQ_BITS   = 2 * Z_BITS - 1;
   localparam int FRAC      = 24;
   localparam int ZMAG_MAX  = (1 << 29) - 1;

   localparam logic [SQ_BITS-1:0] ESC_SUMSQ = SQ_BITS'(1000) << (2 * FRAC);

   localparam int CSR_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_STEP_SCALE,
      REG_PIXEL_FORMAT
   } csr_reg_type;

   typedef enum logic {
      FMT_RGB888,
      FMT_RGB565
   } pix_fmt_type;

   localparam logic [11:0] FRAME_WIDTH_RST  = 12'd1024;
   localparam logic [11:0] FRAME_HEIGHT_RST = 12'd768;
   localparam logic [23:0] STEP_SCALE_RST   = 24'd83886;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [23:0] step_scale;
      pix_fmt_type pixel_format;
   } csr_type;

   typedef struct packed {
      logic                     valid;
      logic                     done;
      logic                     chk;
      logic                     big;
      logic [ITER_BITS-1:0]     n;
      logic signed [Z_BITS-1:0] re;
      logic signed [Z_BITS-1:0] im;
      logic signed [Z_BITS-1:0] cre;
      logic signed [Z_BITS-1:0] cim;
   } cell_bus_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_HALF,
      SEL_RISE,
      SEL_FALL
   } sel_type;

   typedef struct packed {
      sel_type c0;
      sel_type c1;
      sel_type c2;
   } hue_sel_type;

   function automatic hue_sel_type hue_sels(input logic [2:0] hue);
      hue_sel_type s;
      case (hue)
         3'd0: s = '{SEL_HALF, SEL_RISE, SEL_ZERO};
         3'd1: s = '{SEL_FALL, SEL_HALF, SEL_ZERO};
         3'd2: s = '{SEL_ZERO, SEL_HALF, SEL_RISE};
         3'd3: s = '{SEL_ZERO, SEL_FALL, SEL_HALF};
         3'd4: s = '{SEL_RISE, SEL_ZERO, SEL_HALF};
         3'd5: s = '{SEL_HALF, SEL_ZERO, SEL_FALL};
         default: s = '{SEL_ZERO, SEL_ZERO, SEL_ZERO};
      endcase
      return s;
   endfunction

   // step on the ten-step ramp; the top of the ramp is the half level
   function automatic logic [3:0] ramp_step(input sel_type s, input logic [3:0] m);
      logic [3:0] k;
      case (s)
         SEL_HALF: k = 4'd10;
         SEL_RISE: k = m;
         SEL_FALL: k = 4'd10 - m;
         default:  k = 4'd0;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] ramp8(input logic [3:0] k);
      logic [7:0] v;
      case (k)
         4'd0:  v = 8'd0;
         4'd1:  v = 8'd12;
         4'd2:  v = 8'd25;
         4'd3:  v = 8'd38;
         4'd4:  v = 8'd51;
         4'd5:  v = 8'd64;
         4'd6:  v = 8'd76;
         4'd7:  v = 8'd89;
         4'd8:  v = 8'd102;
         4'd9:  v = 8'd115;
         4'd10: v = 8'd128;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] ramp5(input logic [3:0] k);
      logic [4:0] v;
      case (k)
         4'd0:  v = 5'd0;
         4'd1:  v = 5'd1;
         4'd2:  v = 5'd3;
         4'd3:  v = 5'd4;
         4'd4:  v = 5'd6;
         4'd5:  v = 5'd7;
         4'd6:  v = 5'd9;
         4'd7:  v = 5'd10;
         4'd8:  v = 5'd12;
         4'd9:  v = 5'd13;
         4'd10: v = 5'd15;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic [5:0] ramp6(input logic [3:0] k);
      logic [5:0] v;
      case (k)
         4'd0:  v = 6'd0;
         4'd1:  v = 6'd3;
         4'd2:  v = 6'd6;
         4'd3:  v = 6'd9;
         4'd4:  v = 6'd12;
         4'd5:  v = 6'd15;
         4'd6:  v = 6'd18;
         4'd7:  v = 6'd22;
         4'd8:  v = 6'd25;
         4'd9:  v = 6'd28;
         4'd10: v = 6'd31;
         default: v = 6'd0;
      endcase
      return v;
   endfunction

   function automatic logic [23:0] hue_word(input logic [2:0] hue, input logic [3:0] m,
                                            input pix_fmt_type fmt);
      hue_sel_type s;
      logic [3:0]  k0;
      logic [3:0]  k1;
      logic [3:0]  k2;
      logic [23:0] w;
      s  = hue_sels(hue);
      k0 = ramp_step(s.c0, m);
      k1 = ramp_step(s.c1, m);
      k2 = ramp_step(s.c2, m);
      if (fmt == FMT_RGB888) begin
         w = {ramp8(k2), ramp8(k1), ramp8(k0)};
      end else begin
         w = {8'd0, ramp5(k0), ramp6(k1), ramp5(k2)};
      end
      return w;
   endfunction

endpackage

FILE: design/mpc_req_if.sv
`timescale 1ns / 1ps
// pixel coordinate channel
interface mpc_req_if #(
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

FILE: design/mpc_rsp_if.sv
`timescale 1ns / 1ps
// pixel colour result channel
interface mpc_rsp_if ();
   logic        valid;
   logic        ready;
   logic [23:0] pixel_word;
   logic [5:0]  iteration_count;

   modport source (output valid, pixel_word, iteration_count, input ready);
   modport sink   (input valid, pixel_word, iteration_count, output ready);
endinterface

FILE: design/mpc_csr.sv
`timescale 1ns / 1ps
// apb register file: frame size, step scale and pixel format
module mpc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mpc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready,
   output mpc_pkg::csr_type                     csr
);
   import mpc_pkg::*;

   csr_type     csr_ff;
   csr_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign csr     = csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.frame_width  <= FRAME_WIDTH_RST;
         csr_ff.frame_height <= FRAME_HEIGHT_RST;
         csr_ff.step_scale   <= STEP_SCALE_RST;
         csr_ff.pixel_format <= FMT_RGB888;
      end else if (wr_en) begin
         case (reg_sel)
            REG_FRAME_WIDTH:  csr_ff.frame_width  <= pwdata[11:0];
            REG_FRAME_HEIGHT: csr_ff.frame_height <= pwdata[11:0];
            REG_STEP_SCALE:   csr_ff.step_scale   <= pwdata[23:0];
            REG_PIXEL_FORMAT: csr_ff.pixel_format <= pix_fmt_type'(pwdata[0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FRAME_WIDTH:  prdata = 32'(csr_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = 32'(csr_ff.frame_height);
         REG_STEP_SCALE:   prdata = 32'(csr_ff.step_scale);
         REG_PIXEL_FORMAT: prdata = 32'(csr_ff.pixel_format);
         default:          prdata = '0;
      endcase
   end
endmodule

FILE: design/mpc_front.sv
`timescale 1ns / 1ps
// pixel to complex plane mapping, feeds the first iteration cell
module mpc_front #(
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   take,
   input  logic [COORD_BITS-1:0]  pixel_x,
   input  logic [COORD_BITS-1:0]  pixel_y,
   input  mpc_pkg::csr_type       csr,
   output mpc_pkg::cell_bus_type  bus_out
);
   import mpc_pkg::*;

   localparam int DW = (COORD_BITS > 11 ? COORD_BITS : 11) + 1;
   localparam int CW = DW + 25;
   localparam logic signed [CW-1:0] LIM_HI = CW'(ZMAG_MAX);
   localparam logic signed [CW-1:0] LIM_LO = -LIM_HI;

   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [24:0]   scale;
   logic signed [CW-1:0] cre_in;
   logic signed [CW-1:0] cim_in;
   logic signed [CW-1:0] cre_ff;
   logic signed [CW-1:0] cim_ff;
   logic                 valid_ff;
   logic                 big_c;
   cell_bus_type         bus_ff;
   cell_bus_type         bus_in;

   assign dx     = $signed(DW'(pixel_x)) - $signed(DW'(csr.frame_width[11:1]));
   assign dy     = $signed(DW'(pixel_y)) - $signed(DW'(csr.frame_height[11:1]));
   assign scale  = $signed({1'b0, csr.step_scale});
   assign cre_in = dx * scale;
   assign cim_in = dy * scale;

   // a start point with a real or imaginary part of magnitude 32 or more escapes on the first iteration
   assign big_c = (cre_ff > LIM_HI) || (cre_ff < LIM_LO) ||
                  (cim_ff > LIM_HI) || (cim_ff < LIM_LO);

   always_comb begin
      bus_in.valid = valid_ff;
      bus_in.done  = big_c;
      bus_in.chk   = 1'b0;
      bus_in.big   = 1'b0;
      bus_in.n     = big_c ? ITER_BITS'(1) : '0;
      bus_in.re    = cre_ff[Z_BITS-1:0];
      bus_in.im    = cim_ff[Z_BITS-1:0];
      bus_in.cre   = cre_ff[Z_BITS-1:0];
      bus_in.cim   = cim_ff[Z_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         bus_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= take;
         cre_ff   <= cre_in;
         cim_ff   <= cim_in;
         bus_ff   <= bus_in;
      end
   end

   assign bus_out = bus_ff;
endmodule

FILE: design/mpc_cell.sv
`timescale 1ns / 1ps
// one escape-time iteration: square stage then add and escape test stage
module mpc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  mpc_pkg::cell_bus_type bus_in,
   output mpc_pkg::cell_bus_type bus_out
);
   import mpc_pkg::*;

   localparam int NW = Z_BITS + 8;
   localparam logic signed [NW-1:0] LIM_HI = NW'(ZMAG_MAX);
   localparam logic signed [NW-1:0] LIM_LO = -LIM_HI;

   cell_bus_type                a_ff;
   cell_bus_type                b_ff;
   cell_bus_type                b_in;
   logic signed [PROD_BITS-1:0] rr_in;
   logic signed [PROD_BITS-1:0] ii_in;
   logic signed [PROD_BITS-1:0] ri_in;
   logic signed [PROD_BITS-1:0] rr_ff;
   logic signed [PROD_BITS-1:0] ii_ff;
   logic signed [PROD_BITS-1:0] ri_ff;
   logic [SQ_BITS-1:0]          sumsq;
   logic signed [NW-1:0]        nr;
   logic signed [NW-1:0]        ni;
   logic                        esc;
   logic                        big_z;

   assign rr_in = bus_in.re * bus_in.re;
   assign ii_in = bus_in.im * bus_in.im;
   assign ri_in = bus_in.re * bus_in.im;

   // squares of the previous iterate give both its escape test and this step
   assign sumsq = SQ_BITS'(rr_ff[2*Z_BITS-3:0]) + SQ_BITS'(ii_ff[2*Z_BITS-3:0]);
   assign esc   = a_ff.chk && (a_ff.big || (sumsq > ESC_SUMSQ));

   assign nr = $signed(NW'(rr_ff[2*Z_BITS-3:FRAC])) - $signed(NW'(ii_ff[2*Z_BITS-3:FRAC]))
               + NW'(a_ff.cre);
   assign ni = NW'($signed(ri_ff[PROD_BITS-1:FRAC-1])) + NW'(a_ff.cim);

   assign big_z = (nr > LIM_HI) || (nr < LIM_LO) || (ni > LIM_HI) || (ni < LIM_LO);

   always_comb begin
      b_in.valid = a_ff.valid;
      b_in.chk   = 1'b1;
      b_in.cre   = a_ff.cre;
      b_in.cim   = a_ff.cim;
      b_in.re    = nr[Z_BITS-1:0];
      b_in.im    = ni[Z_BITS-1:0];
      if (a_ff.done || esc) begin
         b_in.done = 1'b1;
         b_in.big  = 1'b0;
         b_in.n    = a_ff.n;
      end else begin
         b_in.done = 1'b0;
         b_in.big  = big_z;
         b_in.n    = ITER_BITS'(a_ff.n + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         a_ff  <= bus_in;
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
         b_ff  <= b_in;
      end
   end

   assign bus_out = b_ff;
endmodule

FILE: design/mpc_color.sv
`timescale 1ns / 1ps
// iteration count to hue colour, result beat register
module mpc_color (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  mpc_pkg::cell_bus_type bus_in,
   input  mpc_pkg::pix_fmt_type  pixel_format,
   output logic                  valid,
   output logic [23:0]           pixel_word,
   output logic [5:0]            iteration_count
);
   import mpc_pkg::*;

   localparam int PW = ITER_BITS + 8;
   localparam int QW = PW - 11;

   logic [PW-1:0]        tenth;
   logic [QW-1:0]        q;
   logic [ITER_BITS-1:0] tens;
   logic [3:0]           m;
   logic [QW-1:0]        base;
   logic [2:0]           hue;
   logic                 valid_ff;
   logic [23:0]          word_ff;
   logic [5:0]           count_ff;

   // divide by ten through a reciprocal, exact over the count range
   assign tenth = PW'(bus_in.n) * PW'(205);
   assign q     = tenth[PW-1:11];
   assign tens  = ITER_BITS'(q) * ITER_BITS'(10);
   assign m     = 4'(bus_in.n - tens);

   always_comb begin
      base = '0;
      for (int k = 1; k <= 8; k++) begin
         if (q >= QW'(6 * k)) begin
            base = QW'(6 * k);
         end
      end
   end

   assign hue = 3'(q - base);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= bus_in.valid;
         word_ff  <= hue_word(hue, m, pixel_format);
         count_ff <= bus_in.n[5:0];
      end
   end

   assign valid           = valid_ff;
   assign pixel_word      = word_ff;
   assign iteration_count = count_ff;
endmodule

FILE: design/mandelbrot_pixel_colorizer_core.sv
`timescale 1ns / 1ps
// top level of the mandelbrot escape-time pixel colouriser
// Takes one pixel coordinate per clock and returns one colour beat per pixel, in order.
// The iterations run down a chain of MAX_ITER identical cells, each with a squaring stage
// and an add/escape stage; every pixel runs through the whole chain, whatever its escape
// count.
// When the result beat is held back the whole chain stalls and no new pixel is taken.
// Registers sit at byte addresses 0, 4, 8 and 12: frame width, frame height, step scale
// and pixel format; write them only while no pixel is in flight.
module mandelbrot_pixel_colorizer_core #(
   parameter int MAX_ITER   = mpc_pkg::MAX_ITER_DEF,
   parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mpc_req_if.sink                           req_chan,
   mpc_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mpc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import mpc_pkg::*;

   csr_type      csr;
   cell_bus_type chain [MAX_ITER+1];
   logic         advance;
   logic         rsp_valid;

   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = rsp_valid;

   mpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   mpc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .take    (req_chan.valid),
      .pixel_x (req_chan.pixel_x),
      .pixel_y (req_chan.pixel_y),
      .csr     (csr),
      .bus_out (chain[0])
   );

   for (genvar k = 0; k < MAX_ITER; k++) begin : g_cell
      mpc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .bus_in  (chain[k]),
         .bus_out (chain[k+1])
      );
   end

   mpc_color u_color (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .bus_in          (chain[MAX_ITER]),
      .pixel_format    (csr.pixel_format),
      .valid           (rsp_valid),
      .pixel_word      (rsp_chan.pixel_word),
      .iteration_count (rsp_chan.iteration_count)
   );
endmodule
